// File: sv/plane_box_overlap_test_core_macros.svh
// Assertion helpers, clocked on clk and disabled in reset.
`ifndef PLANE_BOX_OVERLAP_TEST_CORE_MACROS_SVH
`define PLANE_BOX_OVERLAP_TEST_CORE_MACROS_SVH

`define PBO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define PBO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/pbo_pkg.sv
package pbo_pkg;

  localparam int NORM_MAG_BITS = 30;
  localparam int SQRT_STEPS    = 32;
  localparam int SQ_BITS       = 64;
  localparam int ROOT_BITS     = 32;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_BOX    = 2'd1;
  localparam logic [1:0] KIND_POINT  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DEGEN   = 2'd1,
    ST_FEW     = 2'd2,
    ST_NOPLANE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MG_CROSS,
    MG_SQ,
    MG_DOTA,
    MG_DOTB
  } mul_grp_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic     vtx_accept;
    logic     q_load;
    logic     q_box;
    logic     edge_load;
    mul_grp_t mul_grp;
    logic [2:0] mul_idx;
    acc_op_t  acc_op;
    logic     cr_store;
    logic [1:0] cr_idx;
    logic     abs_load;
    logic     norm_shr;
    logic     norm_shl;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     div_init;
    logic     div_step;
    logic     n_store;
    logic [1:0] div_idx;
    logic     qa_p0;
    logic     off_store;
    logic     eval_lo;
    logic     eval_hi;
    logic     eval_pt;
  } cmd_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       pvalid;
    logic       norm_zero;
    logic       norm_hi;
    logic       norm_lo;
    logic       qhit;
  } stat_t;

endpackage

// File: sv/pbo_req_if.sv
interface pbo_req_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic [COORD_BITS-2:0]        extent_w;
  logic [COORD_BITS-2:0]        extent_h;
  logic [COORD_BITS-2:0]        extent_d;
  logic                         last_vertex;

  modport source (output valid, kind, coord_x, coord_y, coord_z,
                  extent_w, extent_h, extent_d, last_vertex, input ready);
  modport sink (input valid, kind, coord_x, coord_y, coord_z,
                extent_w, extent_h, extent_d, last_vertex, output ready);
endinterface

// File: sv/pbo_res_if.sv
interface pbo_res_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] status;

  modport source (output valid, hit, status, input ready);
  modport sink (input valid, hit, status, output ready);
endinterface

// File: sv/pbo_dp.sv
module pbo_dp import pbo_pkg::*; #(
  parameter int COORD_BITS  = 32,
  parameter int COORD_FRAC  = 16,
  parameter int NORMAL_FRAC = 30
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  input  logic signed [COORD_BITS-1:0] p_z,
  input  logic [COORD_BITS-2:0]        ext_w,
  input  logic [COORD_BITS-2:0]        ext_h,
  input  logic [COORD_BITS-2:0]        ext_d,
  input  logic                         last,
  input  logic                         cfg_we,
  input  logic [COORD_BITS-2:0]        cfg_wdata
);

  localparam int NW  = NORMAL_FRAC + 2;
  localparam int EW  = COORD_BITS + 1;
  localparam int MA0 = (EW > NW) ? EW : NW;
  localparam int MA  = (MA0 > NORM_MAG_BITS + 1) ? MA0 : NORM_MAG_BITS + 1;
  localparam int AW  = 2 * MA + 2;
  localparam int OW  = COORD_BITS + 2;
  localparam int TW  = COORD_BITS - 1;
  localparam int DW  = NORM_MAG_BITS + NORMAL_FRAC;
  localparam logic [TW-1:0] TOL_RESET = TW'(((1 << COORD_FRAC) + 5) / 10);

  logic [TW-1:0]                tol;
  logic signed [COORD_BITS-1:0] fv [9];
  logic [1:0]                   cnt;
  logic                         pvalid;
  logic signed [COORD_BITS-1:0] bl [3];
  logic signed [COORD_BITS-1:0] bh [3];
  logic signed [NW-1:0]         n [3];
  logic signed [OW-1:0]         off;
  logic signed [EW-1:0]         e1 [3];
  logic signed [EW-1:0]         e2 [3];
  logic signed [EW-1:0]         qa [3];
  logic signed [EW-1:0]         qb [3];
  logic signed [AW-1:0]         cr [3];
  logic [AW-1:0]                mg [3];
  logic [2:0]                   neg;
  logic signed [MA-1:0]         ma, mb;
  logic signed [2*MA-1:0]       prod;
  logic signed [AW-1:0]         acc, acc_next;
  logic [SQ_BITS-1:0]           sq_s, sq_r, sq_bit, sq_t;
  logic [ROOT_BITS:0]           rem, rs;
  logic [DW-1:0]                num;
  logic [NW-1:0]                q;
  logic                         ge;
  logic                         qhit;
  logic [NORM_MAG_BITS-1:0]     m_div;
  logic                         neg_div;
  logic [AW-1:0]                orm;
  logic signed [COORD_BITS-1:0] p [3];
  logic [TW-1:0]                ext [3];
  logic signed [EW-1:0]         pe [3];
  logic signed [EW-1:0]         pi [3];
  logic                         ovl;
  logic signed [AW-1:0]         offx, rhs, offsh, tolsh, vpt, sh;
  logic signed [NW-1:0]         qs;
  logic [1:0]                   cnt_inc;

  assign p[0] = p_x;
  assign p[1] = p_y;
  assign p[2] = p_z;
  assign ext[0] = ext_w;
  assign ext[1] = ext_h;
  assign ext[2] = ext_d;

  always_comb begin
    ovl = 1'b1;
    for (int i = 0; i < 3; i++) begin
      pi[i] = EW'(p[i]);
      pe[i] = EW'(p[i]) + $signed(EW'(ext[i]));
      if (EW'(bl[i]) > pe[i]) ovl = 1'b0;
      if (EW'(bh[i]) < pi[i]) ovl = 1'b0;
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul_grp)
      MG_CROSS: begin
        case (cmd.mul_idx)
          3'd0: begin ma = MA'(e1[1]); mb = MA'(e2[2]); end
          3'd1: begin ma = MA'(e1[2]); mb = MA'(e2[1]); end
          3'd2: begin ma = MA'(e1[2]); mb = MA'(e2[0]); end
          3'd3: begin ma = MA'(e1[0]); mb = MA'(e2[2]); end
          3'd4: begin ma = MA'(e1[0]); mb = MA'(e2[1]); end
          3'd5: begin ma = MA'(e1[1]); mb = MA'(e2[0]); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      MG_SQ: begin
        case (cmd.mul_idx)
          3'd0: ma = $signed(MA'(mg[0][NORM_MAG_BITS-1:0]));
          3'd1: ma = $signed(MA'(mg[1][NORM_MAG_BITS-1:0]));
          3'd2: ma = $signed(MA'(mg[2][NORM_MAG_BITS-1:0]));
          default: ma = '0;
        endcase
        mb = ma;
      end
      MG_DOTA, MG_DOTB: begin
        case (cmd.mul_idx)
          3'd0: begin
            ma = MA'(n[0]);
            mb = (cmd.mul_grp == MG_DOTA) ? MA'(qa[0]) : MA'(qb[0]);
          end
          3'd1: begin
            ma = MA'(n[1]);
            mb = (cmd.mul_grp == MG_DOTA) ? MA'(qa[1]) : MA'(qb[1]);
          end
          3'd2: begin
            ma = MA'(n[2]);
            mb = (cmd.mul_grp == MG_DOTA) ? MA'(qa[2]) : MA'(qb[2]);
          end
          default: begin ma = '0; mb = '0; end
        endcase
      end
    endcase
  end

  always_comb begin
    unique case (cmd.acc_op)
      ACC_HOLD: acc_next = acc;
      ACC_LOAD: acc_next = AW'(prod);
      ACC_ADD:  acc_next = acc + AW'(prod);
      ACC_SUB:  acc_next = acc - AW'(prod);
    endcase
  end

  always_comb begin
    unique case (cmd.div_idx)
      2'd0: begin m_div = mg[0][NORM_MAG_BITS-1:0]; neg_div = neg[0]; end
      2'd1: begin m_div = mg[1][NORM_MAG_BITS-1:0]; neg_div = neg[1]; end
      2'd2: begin m_div = mg[2][NORM_MAG_BITS-1:0]; neg_div = neg[2]; end
      default: begin m_div = '0; neg_div = 1'b0; end
    endcase
  end

  assign orm   = mg[0] | mg[1] | mg[2];
  assign sq_t  = sq_r + sq_bit;
  assign rs    = {rem[ROOT_BITS-1:0], num[DW-1]};
  assign ge    = rs >= {1'b0, sq_r[ROOT_BITS-1:0]};
  assign qs    = $signed(q);
  assign offx  = AW'(off);
  assign rhs   = (-offx) <<< NORMAL_FRAC;
  assign offsh = offx <<< NORMAL_FRAC;
  assign tolsh = $signed(AW'(tol)) <<< NORMAL_FRAC;
  assign vpt   = acc + offsh;
  assign sh    = acc >>> NORMAL_FRAC;
  assign cnt_inc = (cnt < 2'd3) ? cnt + 2'd1 : cnt;

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    acc  <= acc_next;

    if (cmd.vtx_accept) begin
      for (int i = 0; i < 3; i++) begin
        if (cnt == 2'd0) begin
          bl[i] <= p[i];
          bh[i] <= p[i];
        end else begin
          if (p[i] < bl[i]) bl[i] <= p[i];
          if (p[i] > bh[i]) bh[i] <= p[i];
        end
        if (cnt < 2'd3) fv[4'(cnt) * 4'd3 + 4'(i)] <= p[i];
      end
    end

    if (cmd.q_load) begin
      for (int i = 0; i < 3; i++) begin
        if (cmd.q_box && n[i][NW-1]) begin
          qa[i] <= pe[i];
          qb[i] <= pi[i];
        end else begin
          qa[i] <= pi[i];
          qb[i] <= pe[i];
        end
      end
    end
    if (cmd.qa_p0) begin
      for (int i = 0; i < 3; i++) qa[i] <= EW'(fv[i]);
    end

    if (cmd.edge_load) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EW'(fv[i]) - EW'(fv[3+i]);
        e2[i] <= EW'(fv[i]) - EW'(fv[6+i]);
      end
    end

    if (cmd.cr_store) begin
      unique case (cmd.cr_idx)
        2'd0: cr[0] <= acc_next;
        2'd1: cr[1] <= acc_next;
        2'd2: cr[2] <= acc_next;
        default: ;
      endcase
    end

    for (int i = 0; i < 3; i++) begin
      if (cmd.abs_load) begin
        mg[i]  <= cr[i][AW-1] ? AW'(-cr[i]) : AW'(cr[i]);
        neg[i] <= cr[i][AW-1];
      end else if (cmd.norm_shr) begin
        mg[i] <= mg[i] >> 1;
      end else if (cmd.norm_shl) begin
        mg[i] <= mg[i] << 1;
      end
    end

    if (cmd.sqrt_init) begin
      sq_s   <= acc[SQ_BITS-1:0];
      sq_r   <= '0;
      sq_bit <= SQ_BITS'(1) << (SQ_BITS - 2);
    end else if (cmd.sqrt_step) begin
      if (sq_s >= sq_t) begin
        sq_s <= sq_s - sq_t;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end

    if (cmd.div_init) begin
      num <= {m_div, {NORMAL_FRAC{1'b0}}};
      rem <= '0;
      q   <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? rs - {1'b0, sq_r[ROOT_BITS-1:0]} : rs;
      q   <= {q[NW-2:0], ge};
      num <= num << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol    <= TOL_RESET;
      cnt    <= '0;
      pvalid <= 1'b0;
      off    <= '0;
      qhit   <= 1'b0;
      for (int i = 0; i < 3; i++) n[i] <= '0;
    end else begin
      if (cfg_we) tol <= cfg_wdata;
      if (cmd.vtx_accept) begin
        if (cnt == 2'd0) pvalid <= 1'b0;
        cnt <= last ? 2'd0 : cnt_inc;
      end
      if (cmd.n_store) begin
        unique case (cmd.div_idx)
          2'd0: n[0] <= neg_div ? -qs : qs;
          2'd1: n[1] <= neg_div ? -qs : qs;
          2'd2: n[2] <= neg_div ? -qs : qs;
          default: ;
        endcase
      end
      if (cmd.off_store) begin
        off    <= OW'(-sh);
        pvalid <= 1'b1;
      end
      if (cmd.q_load) qhit <= cmd.q_box ? ovl : 1'b0;
      if (cmd.eval_lo && (rhs < acc)) qhit <= 1'b0;
      if (cmd.eval_hi && (acc < rhs)) qhit <= 1'b0;
      if (cmd.eval_pt) qhit <= (vpt < tolsh) && (vpt > -tolsh);
    end
  end

  assign stat.cnt       = cnt;
  assign stat.pvalid    = pvalid;
  assign stat.norm_zero = (orm == '0);
  assign stat.norm_hi   = |(orm >> NORM_MAG_BITS);
  assign stat.norm_lo   = !orm[NORM_MAG_BITS-1];
  assign stat.qhit      = qhit;

endmodule

// File: sv/pbo_ctrl.sv
`include "plane_box_overlap_test_core_macros.svh"

module pbo_ctrl import pbo_pkg::*; #(
  parameter int NORMAL_FRAC = 30
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  input  logic       in_last,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output logic       out_hit,
  output logic [1:0] out_status,
  input  stat_t      stat,
  output cmd_t       cmd
);

  localparam int DW  = NORM_MAG_BITS + NORMAL_FRAC;
  localparam int IW  = $clog2(((DW + 2) > (SQRT_STEPS + 1)) ? DW + 2 : SQRT_STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE, S_MAC, S_ABS, S_NORM, S_SQRT, S_DIV,
    S_PREP, S_OFFSET, S_BOXLO, S_BOXHI, S_POINT, S_DONE
  } state_t;

  typedef enum logic [1:0] {JOB_BUILD, JOB_BOX, JOB_POINT} job_t;

  state_t     state;
  job_t       job;
  mul_grp_t   grp;
  logic [2:0] step;
  logic [2:0] mac_len;
  logic [IW-1:0] iter;
  logic [1:0] didx;
  status_t    pend_st;
  logic [2:0] j;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign j        = step - 3'd1;

  always_comb begin
    cmd         = '0;
    cmd.mul_grp = grp;
    cmd.mul_idx = step;
    cmd.div_idx = didx;
    cmd.acc_op  = ACC_HOLD;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_VERTEX) cmd.vtx_accept = 1'b1;
          if ((in_kind == KIND_BOX || in_kind == KIND_POINT) && stat.pvalid) begin
            cmd.q_load = 1'b1;
            cmd.q_box  = (in_kind == KIND_BOX);
          end
        end
      end
      S_EDGE: cmd.edge_load = 1'b1;
      S_MAC: begin
        if (step != 3'd0) begin
          if (grp == MG_CROSS) begin
            cmd.acc_op   = j[0] ? ACC_SUB : ACC_LOAD;
            cmd.cr_store = j[0];
            cmd.cr_idx   = j[2:1];
          end else begin
            cmd.acc_op = (j == 3'd0) ? ACC_LOAD : ACC_ADD;
          end
        end
      end
      S_ABS: cmd.abs_load = 1'b1;
      S_NORM: begin
        if (!stat.norm_zero) begin
          if (stat.norm_hi) cmd.norm_shr = 1'b1;
          else if (stat.norm_lo) cmd.norm_shl = 1'b1;
        end
      end
      S_SQRT: begin
        if (iter == '0) cmd.sqrt_init = 1'b1;
        else cmd.sqrt_step = 1'b1;
      end
      S_DIV: begin
        if (iter == '0) cmd.div_init = 1'b1;
        else if (iter == IW'(DW + 1)) cmd.n_store = 1'b1;
        else cmd.div_step = 1'b1;
      end
      S_PREP:   cmd.qa_p0 = 1'b1;
      S_OFFSET: cmd.off_store = 1'b1;
      S_BOXLO:  cmd.eval_lo = 1'b1;
      S_BOXHI:  cmd.eval_hi = 1'b1;
      S_POINT:  cmd.eval_pt = 1'b1;
      S_DONE: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= JOB_BUILD;
      grp       <= MG_CROSS;
      step      <= '0;
      mac_len   <= '0;
      iter      <= '0;
      didx      <= '0;
      pend_st   <= ST_OK;
      out_valid <= 1'b0;
      out_hit   <= 1'b0;
      out_status <= ST_OK;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (in_kind == KIND_VERTEX) begin
              if (in_last) begin
                job <= JOB_BUILD;
                if (stat.cnt < 2'd2) begin
                  pend_st <= ST_FEW;
                  state   <= S_DONE;
                end else begin
                  state <= S_EDGE;
                end
              end
            end else if (in_kind == KIND_BOX || in_kind == KIND_POINT) begin
              job <= (in_kind == KIND_BOX) ? JOB_BOX : JOB_POINT;
              if (!stat.pvalid) begin
                pend_st <= ST_NOPLANE;
                state   <= S_DONE;
              end else begin
                grp     <= MG_DOTA;
                mac_len <= 3'd3;
                step    <= '0;
                state   <= S_MAC;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EDGE: begin
          grp     <= MG_CROSS;
          mac_len <= 3'd6;
          step    <= '0;
          state   <= S_MAC;
        end
        S_MAC: begin
          if (step == mac_len) begin
            step <= '0;
            iter <= '0;
            unique case (grp)
              MG_CROSS: state <= S_ABS;
              MG_SQ:    state <= S_SQRT;
              MG_DOTA: begin
                unique case (job)
                  JOB_BUILD: state <= S_OFFSET;
                  JOB_BOX:   state <= S_BOXLO;
                  JOB_POINT: state <= S_POINT;
                  default:   state <= S_DONE;
                endcase
              end
              MG_DOTB:  state <= S_BOXHI;
            endcase
          end else begin
            step <= step + 3'd1;
          end
        end
        S_ABS: state <= S_NORM;
        S_NORM: begin
          if (stat.norm_zero) begin
            pend_st <= ST_DEGEN;
            state   <= S_DONE;
          end else if (!stat.norm_hi && !stat.norm_lo) begin
            grp     <= MG_SQ;
            mac_len <= 3'd3;
            step    <= '0;
            state   <= S_MAC;
          end
        end
        S_SQRT: begin
          if (iter == IW'(SQRT_STEPS)) begin
            iter  <= '0;
            didx  <= '0;
            state <= S_DIV;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        S_DIV: begin
          if (iter == IW'(DW + 1)) begin
            iter <= '0;
            if (didx == 2'd2) state <= S_PREP;
            else didx <= didx + 2'd1;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        S_PREP: begin
          grp     <= MG_DOTA;
          mac_len <= 3'd3;
          step    <= '0;
          state   <= S_MAC;
        end
        S_OFFSET: begin
          pend_st <= ST_OK;
          state   <= S_DONE;
        end
        S_BOXLO: begin
          grp     <= MG_DOTB;
          mac_len <= 3'd3;
          step    <= '0;
          state   <= S_MAC;
        end
        S_BOXHI, S_POINT: begin
          pend_st <= ST_OK;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            out_status <= pend_st;
            out_hit    <= (pend_st == ST_OK) && ((job == JOB_BUILD) || stat.qhit);
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

  `PBO_ASSERT_NEXT(a_query_busy, accept && (in_kind == KIND_BOX || in_kind == KIND_POINT), state != S_IDLE, "query request did not start work")
  `PBO_ASSERT_NEXT(a_done_waits, state == S_DONE && out_valid && !out_ready, state == S_DONE && out_valid, "result dropped while output stalled")
  `PBO_ASSERT_NOW(a_mac_bound, state == S_MAC, step <= mac_len, "multiply step out of range")

endmodule

// File: sv/plane_box_overlap_test_core.sv
// Builds a plane from polygon vertices (normal from the first three, bounding box
// over all) and answers box and point queries against it. One request at a time:
// a point query runs three products on a single shared multiplier, a box query six.
// A polygon's final vertex runs the plane build: cross product and sum of squares
// on the multiplier, a one-bit-a-cycle normalizing shift, a bit-serial square root,
// a bit-serial divider per normal component and a dot product for the offset. A
// finished result waits in an output register while the next request is taken.
module plane_box_overlap_test_core import pbo_pkg::*; #(
  parameter int COORD_BITS  = 32,
  parameter int COORD_FRAC  = 16,
  parameter int NORMAL_FRAC = 30
) (
  input  logic                  clk,
  input  logic                  rst,
  pbo_req_if.sink               req,
  pbo_res_if.source             res,
  input  logic                  cfg_we,
  input  logic [COORD_BITS-2:0] cfg_wdata
);

  cmd_t       cmd;
  stat_t      stat;
  logic       ready;
  logic [1:0] status;

  pbo_ctrl #(.NORMAL_FRAC(NORMAL_FRAC)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_kind    (req.kind),
    .in_last    (req.last_vertex),
    .in_ready   (ready),
    .out_ready  (res.ready),
    .out_valid  (res.valid),
    .out_hit    (res.hit),
    .out_status (status),
    .stat       (stat),
    .cmd        (cmd)
  );

  pbo_dp #(
    .COORD_BITS  (COORD_BITS),
    .COORD_FRAC  (COORD_FRAC),
    .NORMAL_FRAC (NORMAL_FRAC)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .p_x       (req.coord_x),
    .p_y       (req.coord_y),
    .p_z       (req.coord_z),
    .ext_w     (req.extent_w),
    .ext_h     (req.extent_h),
    .ext_d     (req.extent_d),
    .last      (req.last_vertex),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  assign req.ready  = ready;
  assign res.status = status;

endmodule

// File: verif/tb_plane_box_overlap_test_core.sv
module tb_plane_box_overlap_test_core;
  import pbo_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int SETTLE = 400;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] x, y, z;
    logic [30:0]        w, h, d;
    logic               last;
  } req_item_t;

  typedef struct {
    logic    hit;
    status_t status;
  } verdict_t;

  class plane_scoreboard;
    verdict_t          expected_q[$];
    int                fails;
    longint            tol;
    longint            corner[9];
    int                cnt;
    longint            nrm[3];
    longint            offset;
    longint            blo[3], bhi[3];
    bit                have_plane;

    function new();
      fails = 0;
      tol = 6554;
      cnt = 0;
      have_plane = 0;
      offset = 0;
      for (int i = 0; i < 3; i++) begin
        nrm[i] = 0; blo[i] = 0; bhi[i] = 0;
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      fails++;
    endtask

    function wide_t dot(longint a0, longint a1, longint a2, longint b0, longint b1, longint b2);
      return wide_t'(a0) * wide_t'(b0) + wide_t'(a1) * wide_t'(b1) + wide_t'(a2) * wide_t'(b2);
    endfunction

    function longint unsigned root64(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function status_t build();
      longint e1[3], e2[3], c[3];
      wide_t cr[3], mag[3], mx, dv;
      longint unsigned sum, r, m, q;
      int len;
      for (int i = 0; i < 3; i++) begin
        e1[i] = corner[i] - corner[3+i];
        e2[i] = corner[i] - corner[6+i];
      end
      cr[0] = wide_t'(e1[1]) * wide_t'(e2[2]) - wide_t'(e1[2]) * wide_t'(e2[1]);
      cr[1] = wide_t'(e1[2]) * wide_t'(e2[0]) - wide_t'(e1[0]) * wide_t'(e2[2]);
      cr[2] = wide_t'(e1[0]) * wide_t'(e2[1]) - wide_t'(e1[1]) * wide_t'(e2[0]);
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
        if (mag[i] > mx) mx = mag[i];
      end
      len = 0;
      for (int i = 0; i < 128; i++) if (mx[i]) len = i + 1;
      if (len == 0) return ST_DEGEN;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m = len > 30 ? 64'(mag[i] >> (len - 30)) : 64'(mag[i] << (30 - len));
        c[i] = cr[i] < 0 ? -longint'(m) : longint'(m);
        sum += m * m;
      end
      r = root64(sum);
      if (r == 0) return ST_DEGEN;
      for (int i = 0; i < 3; i++) begin
        m = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
        q = (m << 30) / r;
        nrm[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
      dv = dot(nrm[0], nrm[1], nrm[2], corner[0], corner[1], corner[2]) >>> 30;
      offset = -longint'(dv[63:0]);
      return ST_OK;
    endfunction

    function void note(req_item_t it);
      longint p[3], e[3], lo[3], hi[3];
      wide_t rhs, v, t;
      verdict_t vd;
      p[0] = it.x; p[1] = it.y; p[2] = it.z;
      e[0] = longint'({33'd0, it.w});
      e[1] = longint'({33'd0, it.h});
      e[2] = longint'({33'd0, it.d});
      vd.hit = 0;
      vd.status = ST_OK;
      if (it.kind == KIND_VERTEX) begin
        if (cnt == 0) begin
          have_plane = 0;
          for (int i = 0; i < 3; i++) begin blo[i] = p[i]; bhi[i] = p[i]; end
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (p[i] < blo[i]) blo[i] = p[i];
            if (p[i] > bhi[i]) bhi[i] = p[i];
          end
        end
        if (cnt < 3) begin
          for (int i = 0; i < 3; i++) corner[cnt*3+i] = p[i];
          cnt++;
        end
        if (!it.last) return;
        vd.status = cnt < 3 ? ST_FEW : build();
        have_plane = vd.status == ST_OK;
        vd.hit = have_plane;
        cnt = 0;
      end else if (it.kind != KIND_BOX && it.kind != KIND_POINT) begin
        return;
      end else if (!have_plane) begin
        vd.status = ST_NOPLANE;
      end else if (it.kind == KIND_BOX) begin
        rhs = wide_t'(-offset) <<< 30;
        for (int i = 0; i < 3; i++) begin
          if (nrm[i] >= 0) begin lo[i] = p[i]; hi[i] = p[i] + e[i]; end
          else begin lo[i] = p[i] + e[i]; hi[i] = p[i]; end
        end
        vd.hit = 1;
        if (rhs < dot(nrm[0], nrm[1], nrm[2], lo[0], lo[1], lo[2])) vd.hit = 0;
        if (dot(nrm[0], nrm[1], nrm[2], hi[0], hi[1], hi[2]) < rhs) vd.hit = 0;
        for (int i = 0; i < 3; i++) begin
          if (blo[i] > p[i] + e[i]) vd.hit = 0;
          if (bhi[i] < p[i]) vd.hit = 0;
        end
      end else begin
        v = dot(nrm[0], nrm[1], nrm[2], p[0], p[1], p[2]) + (wide_t'(offset) <<< 30);
        if (v < 0) v = -v;
        t = wide_t'(tol) <<< 30;
        vd.hit = v < t;
      end
      expected_q.push_back(vd);
    endfunction

    task check(logic hit, logic [1:0] status);
      verdict_t vd;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result hit=%0d status=%0d", hit, status));
        return;
      end
      vd = expected_q.pop_front();
      if (status !== vd.status)
        report($sformatf("status got %0d want %0d", status, vd.status));
      if (hit !== vd.hit)
        report($sformatf("hit got %0d want %0d (status %0d)", hit, vd.hit, vd.status));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [30:0] cfg_wdata;
  bit          quiet;
  int          cycles = 0;
  int          sent;
  int          stall_left;
  longint      poly[9];

  pbo_req_if #(.COORD_BITS(32)) req();
  pbo_res_if res();

  plane_scoreboard sb = new();

  plane_box_overlap_test_core dut (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) sb.check(res.hit, res.status);
  end

  initial begin
    res.ready <= 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res.ready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        res.ready <= 0;
      end else begin
        res.ready <= 1;
      end
    end
  end

  function automatic req_item_t mk(logic [1:0] k, longint x, longint y, longint z,
                                   longint w, longint h, longint d, bit last);
    req_item_t it;
    it.kind = k; it.x = x[31:0]; it.y = y[31:0]; it.z = z[31:0];
    it.w = w[30:0]; it.h = h[30:0]; it.d = d[30:0]; it.last = last;
    return it;
  endfunction

  function automatic longint rc(longint span);
    if (span == 0) return longint'($signed($urandom()));
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  function automatic longint clip(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  task automatic send(req_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req.valid <= 1;
    req.kind <= it.kind;
    req.coord_x <= it.x; req.coord_y <= it.y; req.coord_z <= it.z;
    req.extent_w <= it.w; req.extent_h <= it.h; req.extent_d <= it.d;
    req.last_vertex <= it.last;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note(it);
    if (it.kind != 2'd3) sent++;
  endtask

  task automatic drain();
    req.valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_tolerance(longint v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v[30:0];
    @(posedge clk);
    cfg_we <= 0;
    sb.tol = v & 64'h7FFFFFFF;
  endtask

  task automatic polygon(int n, longint span);
    longint base[3], v[3];
    for (int i = 0; i < 3; i++) base[i] = span == 0 ? 0 : rc(32'h3FFF0000 - span);
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        v[i] = clip(base[i] + rc(span));
        if (k < 3) poly[k*3+i] = v[i];
      end
      send(mk(KIND_VERTEX, v[0], v[1], v[2], 0, 0, 0, k == n - 1));
    end
  endtask

  task automatic queries(int n, longint span);
    longint p[3], e[3];
    int a, b;
    for (int k = 0; k < n; k++) begin
      a = $urandom_range(0, 2);
      b = $urandom_range(0, 2);
      case ($urandom_range(0, 4))
        0: begin
          for (int i = 0; i < 3; i++)
            p[i] = clip((poly[a*3+i] + poly[b*3+i]) / 2 + rc($urandom_range(0, 3) * 4096));
          send(mk(KIND_POINT, p[0], p[1], p[2], 0, 0, 0, $urandom_range(0, 1)));
        end
        1: begin
          for (int i = 0; i < 3; i++) p[i] = rc(span);
          send(mk(KIND_POINT, p[0], p[1], p[2], $urandom(), $urandom(), $urandom(),
                  $urandom_range(0, 1)));
        end
        2, 3: begin
          for (int i = 0; i < 3; i++) begin
            e[i] = $urandom_range(0, span == 0 ? 32'h7FFFFFFF : 32'(span));
            p[i] = clip(poly[a*3+i] - e[i] / 2 + rc(span / 8));
          end
          send(mk(KIND_BOX, p[0], p[1], p[2], e[0], e[1], e[2], $urandom_range(0, 1)));
        end
        default: begin
          for (int i = 0; i < 3; i++) p[i] = rc(0);
          send(mk(KIND_BOX, p[0], p[1], p[2], $urandom() >> 1, $urandom() >> 1,
                  $urandom() >> 1, $urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  task automatic noise();
    longint p[3];
    for (int i = 0; i < 3; i++) p[i] = rc(0);
    send(mk($urandom_range(0, 3), p[0], p[1], p[2], $urandom(), $urandom(), $urandom(),
            $urandom_range(0, 1)));
  endtask

  task automatic random_phase(int target);
    longint span;
    int pick;
    while (sent < target) begin
      pick = $urandom_range(0, 9);
      span = $urandom_range(0, 3) == 0 ? 0 : longint'(1) << $urandom_range(4, 28);
      if (pick < 7) begin
        polygon($urandom_range(3, 5), span);
        queries($urandom_range(3, 8), span == 0 ? 64'h40000000 : span);
      end else if (pick == 7) begin
        polygon($urandom_range(1, 2), span);
        queries($urandom_range(1, 2), span == 0 ? 64'h40000000 : span);
      end else if (pick == 8) begin
        for (int i = 0; i < 3; i++) poly[i] = rc(span);
        for (int k = 0; k < 3; k++)
          send(mk(KIND_VERTEX, poly[0] * (k + 1) / 2, poly[1] * (k + 1) / 2,
                  poly[2] * (k + 1) / 2, 0, 0, 0, k == 2));
        queries(1, 64'h10000);
      end else begin
        repeat ($urandom_range(1, 4)) noise();
      end
    end
  endtask

  localparam longint MAXC = 64'sh7FFFFFFF;
  localparam longint MINC = -64'sh80000000;
  localparam longint MAXE = 64'h7FFFFFFF;

  initial begin
    rst <= 1;
    cfg_we <= 0;
    cfg_wdata <= 0;
    quiet = 0;
    sent = 0;
    req.valid <= 0;
    req.kind <= KIND_VERTEX;
    req.coord_x <= 0; req.coord_y <= 0; req.coord_z <= 0;
    req.extent_w <= 0; req.extent_h <= 0; req.extent_d <= 0;
    req.last_vertex <= 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // no plane yet, ignored kind, short polygons
    send(mk(KIND_BOX, 0, 0, 0, MAXE, MAXE, MAXE, 0));
    send(mk(KIND_POINT, MINC, MAXC, 0, 0, 0, 0, 1));
    send(mk(2'd3, MAXC, MAXC, MAXC, MAXE, MAXE, MAXE, 1));
    send(mk(KIND_VERTEX, 5, 6, 7, 0, 0, 0, 1));
    send(mk(KIND_VERTEX, 1, 2, 3, 0, 0, 0, 0));
    send(mk(KIND_VERTEX, 4, 5, 6, 0, 0, 0, 1));
    // collinear, then axis plane z = 1.0 with an extra vertex
    send(mk(KIND_VERTEX, 0, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_VERTEX, 65536, 65536, 65536, 0, 0, 0, 0));
    send(mk(KIND_VERTEX, 131072, 131072, 131072, 0, 0, 0, 1));
    send(mk(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_VERTEX, 0, 0, 65536, 0, 0, 0, 0));
    send(mk(KIND_VERTEX, 655360, 0, 65536, 0, 0, 0, 0));
    send(mk(KIND_VERTEX, 0, 655360, 65536, 0, 0, 0, 0));
    send(mk(KIND_VERTEX, -655360, -655360, 65536, 0, 0, 0, 1));
    send(mk(KIND_POINT, 1000, 2000, 65536 + 6000, 0, 0, 0, 0));
    send(mk(KIND_POINT, 1000, 2000, 65536 + 7000, 0, 0, 0, 0));
    send(mk(KIND_BOX, 0, 0, 0, 65536, 65536, 131072, 0));
    send(mk(KIND_BOX, 0, 0, 131072, 65536, 65536, 65536, 0));
    send(mk(KIND_BOX, MINC, MINC, MINC, MAXE, MAXE, MAXE, 1));
    // extreme corners
    send(mk(KIND_VERTEX, MAXC, MINC, MAXC, 0, 0, 0, 0));
    send(mk(KIND_VERTEX, MINC, MAXC, MINC, 0, 0, 0, 0));
    send(mk(KIND_VERTEX, MINC, MINC, MAXC, 0, 0, 0, 1));
    send(mk(KIND_BOX, MAXC, MAXC, MAXC, MAXE, MAXE, MAXE, 0));
    send(mk(KIND_POINT, MAXC, MINC, MAXC, 0, 0, 0, 0));

    random_phase(350);
    set_tolerance(0);
    random_phase(700);
    set_tolerance(MAXE);
    random_phase(1000);
    set_tolerance($urandom_range(1, 32'h7FFFFFFF));
    random_phase(1200);
    set_tolerance(65536);
    quiet = 1;
    random_phase(1400);

    drain();
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
